>>> rtl/koce_pkg.sv
// ----------------------------------------------------------------------------
// koce_pkg: shared types and constants of the k-of-n combination enumerator
// Holds the payload structs, opcode and register codes, and the control
// bundle that the sequencer broadcasts to the row of index cells.
// ----------------------------------------------------------------------------
package koce_pkg;

  localparam int CARD_W  = 6;
  localparam int IDX_W   = 6;
  localparam int K_W     = 3;
  localparam int N_W     = 6;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 6;
  localparam int OUT_CARDS = 7;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  slot;
    logic [CARD_W-1:0] card_in;
  } in_item_t;

  typedef struct packed {
    logic [CARD_W-1:0] card_0;
    logic [CARD_W-1:0] card_1;
    logic [CARD_W-1:0] card_2;
    logic [CARD_W-1:0] card_3;
    logic [CARD_W-1:0] card_4;
    logic [CARD_W-1:0] card_5;
    logic [CARD_W-1:0] card_6;
    logic              more_left;
  } out_item_t;

  // Broadcast to every cell of the index row.
  typedef struct packed {
    logic           clear;      // start transfer: wipe index and card
    logic           seed_zero;  // seeded cell takes index 0 instead of index + 1
    logic [K_W-1:0] run_k;      // k latched at start
    logic [N_W-1:0] run_n;      // saturated n latched at start
  } cell_ctl_t;

endpackage

>>> rtl/koce_cell.sv
// ----------------------------------------------------------------------------
// koce_cell: one position of the combination index row
// Holds one pool index and the card fetched for it. A seeded cell or a cell
// that receives the token from its left neighbor takes a new index, issues
// a pool read, and hands the token on once its card has arrived.
// ----------------------------------------------------------------------------
module koce_cell #(
  parameter int CELL_ID = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  koce_pkg::cell_ctl_t         ctl,
  input  logic                        seed_i,
  input  logic                        token_i,
  input  logic [koce_pkg::IDX_W-1:0]  left_idx_i,
  input  logic [koce_pkg::CARD_W-1:0] rd_data_i,
  output logic [koce_pkg::IDX_W-1:0]  idx_o,
  output logic [koce_pkg::CARD_W-1:0] card_o,
  output logic                        movable_o,
  output logic                        token_o,
  output logic [koce_pkg::IDX_W-1:0]  addr_o
);
  import koce_pkg::*;

  localparam logic [3:0] ID4 = 4'(CELL_ID);

  logic [IDX_W-1:0]  idx_r;
  logic [CARD_W-1:0] card_r;
  logic              wait_r;
  logic              in_run;
  logic              act;
  logic [IDX_W-1:0]  idx_nxt;

  assign in_run = ({1'b0, ctl.run_k} > ID4);
  assign act    = seed_i | (token_i & in_run);

  always_comb begin
    if (seed_i) begin
      idx_nxt = ctl.seed_zero ? '0 : idx_r + 1'b1;
    end else begin
      idx_nxt = left_idx_i + 1'b1;
    end
  end

  // The index can still move while it stays below n - k + position.
  assign movable_o = in_run &&
                     (({2'b00, idx_r} + {5'b0, ctl.run_k}) <
                      ({2'b00, ctl.run_n} + {4'b0, ID4}));

  assign addr_o  = act ? idx_nxt : '0;
  assign idx_o   = idx_r;
  assign card_o  = card_r;
  assign token_o = wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      card_r <= '0;
      wait_r <= 1'b0;
    end else begin
      if (act) begin
        idx_r  <= idx_nxt;
        wait_r <= 1'b1;
      end else if (ctl.clear) begin
        idx_r  <= '0;
        wait_r <= 1'b0;
      end else begin
        wait_r <= 1'b0;
      end
      if (ctl.clear && !act) begin
        card_r <= '0;
      end else if (wait_r) begin
        card_r <= rd_data_i;
      end
    end
  end

endmodule

>>> rtl/k_of_n_combination_enumerator.sv
// ----------------------------------------------------------------------------
// k_of_n_combination_enumerator: lexicographic k-of-n combination generator
// Loads a card pool slot by slot and walks all k-card combinations of it
// in lexicographic index order, one combination per start or advance item.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_ channel (valid/ready). A load item writes
// one pool slot and produces no result. A start item latches k and n from
// the configuration registers and produces the first combination; each
// advance item produces the next one, with more_left low once the walk is
// exhausted or was never valid. Opcode 3 is dropped without a result.
// Results leave on the out_ channel from an output register.
// A start or advance walks the cell row from the rightmost index that
// moves (the first cell on a start) to cell k - 1; the row fetches one
// pool card per cycle through the single read port of the pool memory.
// A start or advance that changes no index skips the walk. Items are
// worked one at a time; a load may transfer while a result still waits
// in the output register. If the receiver stalls, the result holds and
// the sequencer waits before loading the next result. Reset clears the
// control registers, the index row and the flags; the pool itself holds
// garbage until written.
// ----------------------------------------------------------------------------
module k_of_n_combination_enumerator #(
  parameter int POOL_DEPTH = 52,
  parameter int MAX_CHOOSE = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  koce_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output koce_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [koce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [koce_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import koce_pkg::*;

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // Configuration registers and the values latched at start.
  logic [K_W-1:0] cfg_k_r;
  logic [N_W-1:0] cfg_n_r;
  logic [K_W-1:0] run_k_r, run_k_nxt;
  logic [N_W-1:0] run_n_r, run_n_nxt;
  logic           active_r, active_nxt;
  logic           more_r, more_nxt;
  logic [1:0]     state_r, state_nxt;

  logic           out_valid_r;
  out_item_t      out_r;

  // Pool memory with one write and one registered read port.
  logic [CARD_W-1:0] pool_mem [POOL_DEPTH];
  logic [CARD_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;

  // Cell row.
  cell_ctl_t         ctl;
  logic [MAX_CHOOSE-1:0] seed_vec;
  logic [MAX_CHOOSE-1:0] movable_vec;
  logic [MAX_CHOOSE-1:0] token_vec;
  logic [IDX_W-1:0]  idx_w  [MAX_CHOOSE];
  logic [CARD_W-1:0] card_w [MAX_CHOOSE];
  logic [IDX_W-1:0]  addr_w [MAX_CHOOSE];

  logic              in_fire;
  logic              is_load, is_start, is_adv;
  logic [6:0]        n_sat7;
  logic [N_W-1:0]    n_sat;
  logic              start_bad;
  logic              found;
  logic [MAX_CHOOSE-1:0] pivot_vec;
  logic              last_wait;
  logic [CARD_W-1:0] ocard [OUT_CARDS];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_load   = in_fire && (in_data.opcode == OP_LOAD);
  assign is_start  = in_fire && (in_data.opcode == OP_START);
  assign is_adv    = in_fire && (in_data.opcode == OP_ADVANCE);

  // n saturates to the pool depth; a start with an unusable k goes inactive.
  assign n_sat7    = ({1'b0, cfg_n_r} > 7'(POOL_DEPTH)) ? 7'(POOL_DEPTH) : {1'b0, cfg_n_r};
  assign n_sat     = n_sat7[N_W-1:0];
  assign start_bad = (cfg_k_r == '0) || ({1'b0, cfg_k_r} > 4'(MAX_CHOOSE)) ||
                     ({3'b000, cfg_k_r} > n_sat);

  // Rightmost cell whose index can still move becomes the pivot.
  always_comb begin
    pivot_vec = '0;
    for (int i = 0; i < MAX_CHOOSE; i++) begin
      if (movable_vec[i]) begin
        pivot_vec = '0;
        pivot_vec[i] = 1'b1;
      end
    end
  end
  assign found = |movable_vec;

  always_comb begin
    seed_vec = '0;
    if (is_start && !start_bad) begin
      seed_vec[0] = 1'b1;
    end else if (is_adv && active_r && found) begin
      seed_vec = pivot_vec;
    end
  end

  assign ctl.clear     = is_start;
  assign ctl.seed_zero = is_start;
  assign ctl.run_k     = run_k_r;
  assign ctl.run_n     = run_n_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_CHOOSE; gi++) begin : g_cell
      logic [IDX_W-1:0] left_idx;
      logic             left_tok;
      if (gi == 0) begin : g_first
        assign left_idx = '0;
        assign left_tok = 1'b0;
      end else begin : g_rest
        assign left_idx = idx_w[gi-1];
        assign left_tok = token_vec[gi-1];
      end
      koce_cell #(
        .CELL_ID(gi)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .seed_i     (seed_vec[gi]),
        .token_i    (left_tok),
        .left_idx_i (left_idx),
        .rd_data_i  (rd_data_r),
        .idx_o      (idx_w[gi]),
        .card_o     (card_w[gi]),
        .movable_o  (movable_vec[gi]),
        .token_o    (token_vec[gi]),
        .addr_o     (addr_w[gi])
      );
    end
  endgenerate

  // Only the acting cell drives a nonzero address, so an OR selects it.
  always_comb begin
    rd_addr = '0;
    for (int i = 0; i < MAX_CHOOSE; i++) begin
      rd_addr = rd_addr | addr_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (is_load && ({1'b0, in_data.slot} < 7'(POOL_DEPTH))) begin
      pool_mem[in_data.slot[AW-1:0]] <= in_data.card_in;
    end
    rd_data_r <= pool_mem[rd_addr[AW-1:0]];
  end

  // The walk is over when the last in-use cell is receiving its card.
  always_comb begin
    last_wait = 1'b0;
    for (int i = 0; i < MAX_CHOOSE; i++) begin
      if (token_vec[i] && ((4'(i) + 4'd1) == {1'b0, run_k_r})) begin
        last_wait = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    run_k_nxt  = run_k_r;
    run_n_nxt  = run_n_r;
    active_nxt = active_r;
    more_nxt   = more_r;
    case (state_r)
      ST_IDLE: begin
        if (is_start) begin
          run_n_nxt = n_sat;
          if (start_bad) begin
            run_k_nxt  = '0;
            active_nxt = 1'b0;
            more_nxt   = 1'b0;
            state_nxt  = ST_EMIT;
          end else begin
            run_k_nxt  = cfg_k_r;
            active_nxt = 1'b1;
            more_nxt   = 1'b1;
            state_nxt  = ST_WALK;
          end
        end else if (is_adv) begin
          if (!active_r) begin
            more_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end else if (!found) begin
            active_nxt = 1'b0;
            more_nxt   = 1'b0;
            state_nxt  = ST_EMIT;
          end else begin
            more_nxt  = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (last_wait) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Cards past k read as zero.
  generate
    for (gi = 0; gi < OUT_CARDS; gi++) begin : g_ocard
      if (gi < MAX_CHOOSE) begin : g_used
        assign ocard[gi] = ({1'b0, run_k_r} > 4'(gi)) ? card_w[gi] : '0;
      end else begin : g_unused
        assign ocard[gi] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r     <= '0;
      cfg_n_r     <= '0;
      run_k_r     <= '0;
      run_n_r     <= '0;
      active_r    <= 1'b0;
      more_r      <= 1'b0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CHOOSE_COUNT: cfg_k_r <= cfg_wdata[K_W-1:0];
          REG_POOL_SIZE:    cfg_n_r <= cfg_wdata[N_W-1:0];
          default: begin
          end
        endcase
      end
      run_k_r  <= run_k_nxt;
      run_n_r  <= run_n_nxt;
      active_r <= active_nxt;
      more_r   <= more_nxt;
      state_r  <= state_nxt;
      if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
      out_r.card_0    <= ocard[0];
      out_r.card_1    <= ocard[1];
      out_r.card_2    <= ocard[2];
      out_r.card_3    <= ocard[3];
      out_r.card_4    <= ocard[4];
      out_r.card_5    <= ocard[5];
      out_r.card_6    <= ocard[6];
      out_r.more_left <= more_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  logic tail_clear;
  always_comb begin
    tail_clear = 1'b1;
    for (int i = 0; i < MAX_CHOOSE; i++) begin
      if (({1'b0, run_k_r} <= 4'(i)) && (card_w[i] != '0 || idx_w[i] != '0)) begin
        tail_clear = 1'b0;
      end
    end
  end

  // At most one cell waits for pool data at a time.
  a_one_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(token_vec))
    else $error("more than one cell awaits pool data");

  // A walk only runs on an active enumeration.
  a_walk_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> active_r)
    else $error("walk in progress while enumeration is inactive");

  // Cells past k keep a zero index and a zero card.
  a_tail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WALK) |-> tail_clear)
    else $error("cell beyond k holds a nonzero value");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the k-of-n combination enumerator
// Loads card pools, programs k and n, and walks combinations with start and
// advance items under random sender gaps and receiver stalls. Every result
// is checked field by field against an in-bench model of the enumeration.
// ----------------------------------------------------------------------------
module testbench;
  import koce_pkg::*;

  localparam int POOL_DEPTH   = 52;
  localparam int MAX_CHOOSE   = 7;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int FINAL_WAIT   = 2000;
  localparam int RANDOM_ITEMS = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  k_of_n_combination_enumerator #(
    .POOL_DEPTH(POOL_DEPTH),
    .MAX_CHOOSE(MAX_CHOOSE)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Enumerator model. It mirrors the pool, the index row, the chosen cards,
  // the active flag and both the programmed and the latched k and n.
  // --------------------------------------------------------------------------
  logic [CARD_W-1:0] pool_model [POOL_DEPTH];
  int unsigned       pos_model [MAX_CHOOSE];
  logic [CARD_W-1:0] chosen_model [MAX_CHOOSE];
  bit                active_model;
  int unsigned       run_k_model;
  int unsigned       run_n_model;
  int unsigned       cfg_k_model;
  int unsigned       cfg_n_model;

  out_item_t combos_due[$];   // combinations still owed by the block
  int        failures;
  int        results_seen;
  int        items_sent;      // transfers that the block acts on
  int        cycle_count;
  int        burst_left;

  // Receiver stall pattern state.
  int style;
  int style_left;
  int hold_left;
  bit hold_val;

  // Cards past the latched k read as zero in every result.
  function automatic out_item_t combo_result(input bit more);
    logic [CARD_W-1:0] c [OUT_CARDS];
    for (int i = 0; i < OUT_CARDS; i++)
      c[i] = (i < run_k_model && i < MAX_CHOOSE) ? chosen_model[i] : '0;
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], more};
  endfunction

  function automatic logic [CARD_W-1:0] pool_card(input int unsigned idx);
    return (idx < POOL_DEPTH) ? pool_model[idx] : '0;
  endfunction

  // Applies one accepted item to the model. Returns 1 when the item owes a
  // result, which is then placed in res.
  function automatic bit predict_combination(input in_item_t it, output out_item_t res);
    int unsigned k;
    int unsigned n;
    int unsigned pos;
    bit          found;
    res = '0;
    case (it.opcode)
      OP_LOAD: begin
        // Slots past the pool depth fall on the floor.
        if (it.slot < POOL_DEPTH)
          pool_model[it.slot] = it.card_in;
        return 1'b0;
      end
      OP_START: begin
        k = cfg_k_model;
        n = (cfg_n_model > POOL_DEPTH) ? POOL_DEPTH : cfg_n_model;
        for (int i = 0; i < MAX_CHOOSE; i++) begin
          pos_model[i] = 0;
          chosen_model[i] = '0;
        end
        run_n_model = n;
        if (k == 0 || k > MAX_CHOOSE || k > n) begin
          // Nothing to choose: inactive, and every card reads zero.
          active_model = 1'b0;
          run_k_model = 0;
          res = combo_result(1'b0);
        end else begin
          run_k_model = k;
          for (int i = 0; i < k; i++) begin
            pos_model[i] = i;
            chosen_model[i] = pool_card(i);
          end
          active_model = 1'b1;
          res = combo_result(1'b1);
        end
        return 1'b1;
      end
      OP_ADVANCE: begin
        k = run_k_model;
        n = run_n_model;
        if (!active_model || k == 0 || k > MAX_CHOOSE) begin
          res = combo_result(1'b0);
          return 1'b1;
        end
        // Find the rightmost index that still has room to move right.
        found = 1'b0;
        pos = k;
        while (pos > 0 && !found) begin
          if (pos_model[pos-1] + k < n + pos - 1)
            found = 1'b1;
          else
            pos--;
        end
        if (!found) begin
          // Exhausted: the last combination comes back with more_left low.
          active_model = 1'b0;
          res = combo_result(1'b0);
        end else begin
          pos_model[pos-1] = pos_model[pos-1] + 1;
          chosen_model[pos-1] = pool_card(pos_model[pos-1]);
          for (int i = pos; i < k; i++) begin
            pos_model[i] = pos_model[i-1] + 1;
            chosen_model[i] = pool_card(pos_model[i]);
          end
          res = combo_result(1'b1);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10)
      $display("mismatch at result %0d: %s", results_seen, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog and receiver.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // The receiver moves between three habits: always ready, ready at random
  // with odds of three in four, and alternating runs of ready and stalled.
  always @(negedge clk) begin
    if (style_left == 0) begin
      style = $urandom_range(0, 2);
      style_left = $urandom_range(30, 150);
    end
    style_left--;
    case (style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_val = !hold_val;
          hold_left = hold_val ? $urandom_range(1, 4) : $urandom_range(1, 6);
        end
        hold_left--;
        out_ready <= hold_val;
      end
    endcase
  end

  // Each result transfer is compared, field by field, with the oldest
  // combination still owed.
  always @(posedge clk) begin : result_check
    out_item_t         want;
    logic [CARD_W-1:0] got_c [OUT_CARDS];
    logic [CARD_W-1:0] want_c [OUT_CARDS];
    logic              got_more;
    logic              want_more;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (combos_due.size() == 0) begin
        note_failure($sformatf("result %h arrived with nothing expected", out_data));
      end else begin
        want = combos_due.pop_front();
        {got_c[0], got_c[1], got_c[2], got_c[3], got_c[4], got_c[5], got_c[6],
         got_more} = out_data;
        {want_c[0], want_c[1], want_c[2], want_c[3], want_c[4], want_c[5],
         want_c[6], want_more} = want;
        for (int i = 0; i < OUT_CARDS; i++)
          if (got_c[i] !== want_c[i])
            note_failure($sformatf("card_%0d expected %0d, got %0d",
                                   i, want_c[i], got_c[i]));
        if (got_more !== want_more)
          note_failure($sformatf("more_left expected %0b, got %0b",
                                 want_more, got_more));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts valid
  // drops for a random gap. Valid stays high across the items of a
  // burst, so the next payload simply replaces the last one.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    out_item_t res;
    int        gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (predict_combination(it, res))
      combos_due.push_back(res);
    if (!(it.opcode == OP_NOP || (it.opcode == OP_LOAD && it.slot >= POOL_DEPTH)))
      items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 12);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_load(input int unsigned slot, input int unsigned card);
    in_item_t it;
    it.opcode  = OP_LOAD;
    it.slot    = slot[IDX_W-1:0];
    it.card_in = card[CARD_W-1:0];
    send_item(it);
  endtask

  // Start, advance and no-op items carry random slot and card bits, which
  // the block must ignore.
  task automatic send_op(input logic [OP_W-1:0] op);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom()));
    it.opcode = op;
    send_item(it);
  endtask

  // Drops valid and waits until every owed combination has been taken,
  // then lets a trailing load settle before the registers may change.
  task automatic wait_drain();
    @(negedge clk) in_valid <= 1'b0;
    while (combos_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_CHOOSE_COUNT: cfg_k_model = value[K_W-1:0];
      REG_POOL_SIZE:    cfg_n_model = value;
      default: ;
    endcase
  endtask

  // Programs k and n in random order. The bits of the choose register above
  // k are random and must be dropped by the block.
  task automatic set_choice(input int unsigned k, input int unsigned n);
    logic [CFG_DATA_W-1:0] kval;
    kval = CFG_DATA_W'($urandom());
    kval[K_W-1:0] = k[K_W-1:0];
    wait_drain();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_CHOOSE_COUNT, kval);
      write_reg(REG_POOL_SIZE, n[CFG_DATA_W-1:0]);
    end else begin
      write_reg(REG_POOL_SIZE, n[CFG_DATA_W-1:0]);
      write_reg(REG_CHOOSE_COUNT, kval);
    end
  endtask

  // Advances until the walk runs out or cap advances have gone, then a few
  // more past the end. With noise on, stray loads, no-ops and a register
  // change between advances are mixed in; the walk must keep its latched
  // k and n and read the pool as it stands.
  task automatic walk_combinations(input int cap, input bit noisy);
    int steps;
    int retune_at;
    steps = 0;
    retune_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : -1;
    while (active_model && steps < cap) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 2) == 0)
          send_op(OP_NOP);
        else
          send_load($urandom_range(0, 63), $urandom_range(0, 63));
      end
      if (noisy && steps == retune_at)
        set_choice($urandom_range(0, 7), $urandom_range(0, 63));
      send_op(OP_ADVANCE);
      steps++;
    end
    repeat ($urandom_range(0, 2)) send_op(OP_ADVANCE);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Corner cases on a four-card pool: start and advance before anything is
  // programmed, loads of extreme cards and out-of-range slots, a no-op, a
  // full walk with a register change and a pool write in the middle, and
  // starts with k of zero, k above n and k equal to n.
  task automatic test_directed_corners();
    send_op(OP_START);
    send_op(OP_ADVANCE);
    send_load(0, 0);
    send_load(1, 51);
    send_load(2, 63);
    send_load(3, 42);
    send_load(52, 21);
    send_load(63, 63);
    send_op(OP_NOP);

    set_choice(2, 4);
    send_op(OP_START);
    send_op(OP_ADVANCE);
    // The running walk keeps k = 2 and n = 4 across this change.
    set_choice(7, 0);
    send_op(OP_ADVANCE);
    send_load(2, 17);
    repeat (5) send_op(OP_ADVANCE);

    set_choice(5, 4);
    send_op(OP_START);
    send_op(OP_ADVANCE);
    set_choice(0, 4);
    send_op(OP_START);
    set_choice(4, 4);
    send_op(OP_START);
    send_op(OP_ADVANCE);
  endtask

  // Fills every pool slot, then runs the largest k against a pool size
  // past the depth, which saturates, and walks k = 1 over the whole pool.
  task automatic test_full_pool();
    for (int s = 0; s < POOL_DEPTH; s++)
      send_load(s, $urandom_range(0, 63));
    set_choice(MAX_CHOOSE, 63);
    send_op(OP_START);
    walk_combinations(4, 1'b0);
    set_choice(MAX_CHOOSE, POOL_DEPTH);
    send_op(OP_START);
    walk_combinations(3, 1'b0);
    set_choice(1, POOL_DEPTH);
    send_op(OP_START);
    walk_combinations(POOL_DEPTH, 1'b0);
  endtask

  // Random rounds. Most are complete walks on small pools so that they run
  // out; some use wide pool sizes, some have k above n or zero, and a few
  // are bare noise with random opcodes.
  task automatic test_random_enumerations();
    int          stop_at;
    int unsigned k;
    int unsigned n;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          in_item_t it;
          it = in_item_t'($bits(in_item_t)'($urandom()));
          send_item(it);
        end
      end else begin
        k = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, MAX_CHOOSE);
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(0, 63);
          1:       n = $urandom_range(0, k);
          default: n = k + $urandom_range(0, 3);
        endcase
        set_choice(k, n);
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 4))
            send_load($urandom_range(0, POOL_DEPTH - 1), $urandom_range(0, 63));
        send_op(OP_START);
        walk_combinations(48, 1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    active_model = 1'b0;
    run_k_model  = 0;
    run_n_model  = 0;
    cfg_k_model  = 0;
    cfg_n_model  = 0;
    for (int i = 0; i < MAX_CHOOSE; i++) begin
      pos_model[i] = 0;
      chosen_model[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed_corners();
    test_full_pool();
    test_random_enumerations();

    // Let the last results come home, with a bound, then settle.
    @(negedge clk) in_valid <= 1'b0;
    for (int w = 0; w < FINAL_WAIT && combos_due.size() != 0; w++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (combos_due.size() != 0)
      note_failure($sformatf("%0d combinations never arrived", combos_due.size()));

    if (failures == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
